[src/acep_pkg.sv]
// Shared widths, action codes and the command format passed from the parser to the executor.
package acep_pkg;

   // Field widths
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned VALUE_W  = 16;
   localparam int unsigned ACTION_W = 2;
   localparam int unsigned MODE_W   = 2;

   // Configuration port
   localparam int unsigned CSR_INDEX_W = 1;
   localparam int unsigned CSR_DATA_W  = 16;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_ROWS = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCREEN_COLS = 1'b1;
   localparam logic [CSR_DATA_W-1:0]  SCREEN_ROWS_RESET = 16'd25;
   localparam logic [CSR_DATA_W-1:0]  SCREEN_COLS_RESET = 16'd80;

   // Parameter collection
   localparam int unsigned MAX_PARAMS = 16;
   localparam int unsigned PCNT_W     = $clog2(MAX_PARAMS + 1);

   // Command queue between parser and executor
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Result action codes
   localparam logic [ACTION_W-1:0] ACT_PRINT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_CURSOR = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

   // One decoded command. For a cursor move arg_a/arg_b are the raw row and
   // column parameters (defaults applied); for a clear arg_a holds the mode.
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [BYTE_W-1:0]   char_code;
      logic [VALUE_W-1:0]  arg_a;
      logic [VALUE_W-1:0]  arg_b;
   } cmd_type;

endpackage

[src/acep_front.sv]
// Byte parser: tracks text/escape/CSI state, collects parameters, emits decoded commands.
module acep_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [acep_pkg::BYTE_W-1:0]  req_byte_in,
   output logic                         enq_valid,
   output acep_pkg::cmd_type            enq_entry,
   input  logic                         enq_full
);
   import acep_pkg::*;

   localparam logic [1:0] ST_TEXT = 2'd0;
   localparam logic [1:0] ST_ESC  = 2'd1;
   localparam logic [1:0] ST_CSI  = 2'd2;

   localparam logic [BYTE_W-1:0] CH_ESC     = 8'h1B;
   localparam logic [BYTE_W-1:0] CH_LBRACK  = 8'h5B;
   localparam logic [BYTE_W-1:0] CH_SEMI    = 8'h3B;
   localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
   localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CH_LOWER_Z = 8'h7A;
   localparam logic [BYTE_W-1:0] CH_H       = 8'h48;
   localparam logic [BYTE_W-1:0] CH_F       = 8'h66;
   localparam logic [BYTE_W-1:0] CH_J       = 8'h4A;

   localparam int unsigned LEAD_SLOTS = 2;
   localparam int unsigned ACC_W      = VALUE_W + 4;
   localparam logic [ACC_W-1:0] VALUE_MAX = ACC_W'({VALUE_W{1'b1}});

   logic [1:0]          state_ff, state_in;
   logic [VALUE_W-1:0]  partial_ff, partial_in;
   logic                started_ff, started_in;
   logic                after_sep_ff, after_sep_in;
   logic [PCNT_W-1:0]   stored_ff, stored_in;
   logic [VALUE_W-1:0]  lead_value_ff [LEAD_SLOTS];
   logic                lead_present_ff [LEAD_SLOTS];

   logic                req_fire;
   logic                in_csi;
   logic                is_digit;
   logic                is_semi;
   logic                is_letter;
   logic                do_push;
   logic                push_ok;
   logic [PCNT_W-1:0]   stored_after;
   logic                lead_we [LEAD_SLOTS];
   logic [VALUE_W-1:0]  lead_value_eff [LEAD_SLOTS];
   logic                lead_present_eff [LEAD_SLOTS];
   logic [ACC_W-1:0]    digit_acc;
   logic [VALUE_W-1:0]  row_param;
   logic [VALUE_W-1:0]  col_param;
   logic [VALUE_W-1:0]  mode_param;

   // Accept a byte only when the queue has room
   assign req_stall = enq_full;
   assign req_fire  = req_valid && !req_stall;

   // Classify the byte
   assign in_csi    = (state_ff == ST_CSI);
   assign is_digit  = (req_byte_in >= CH_ZERO) && (req_byte_in <= CH_NINE);
   assign is_semi   = (req_byte_in == CH_SEMI);
   assign is_letter = ((req_byte_in >= CH_UPPER_A) && (req_byte_in <= CH_UPPER_Z)) ||
                      ((req_byte_in >= CH_LOWER_A) && (req_byte_in <= CH_LOWER_Z));

   // Push the pending parameter on ';' or on a final letter with pending input
   assign do_push = req_fire && in_csi &&
                    (is_semi || (is_letter && (started_ff || after_sep_ff)));
   assign push_ok = (stored_ff < PCNT_W'(MAX_PARAMS));
   assign stored_after = (do_push && push_ok) ? stored_ff + PCNT_W'(1) : stored_ff;

   // Leading parameter slots as seen after this byte's push
   always_comb begin
      for (int k = 0; k < LEAD_SLOTS; k++) begin
         lead_we[k] = do_push && push_ok && (stored_ff == PCNT_W'(k));
         lead_value_eff[k]   = lead_we[k] ? (started_ff ? partial_ff : '0) : lead_value_ff[k];
         lead_present_eff[k] = lead_we[k] ? started_ff : lead_present_ff[k];
      end
   end

   // Saturating decimal accumulate
   assign digit_acc = ACC_W'(partial_ff) * ACC_W'(10) + ACC_W'(req_byte_in[3:0]);

   // Parameter lookup with defaults
   assign row_param = ((stored_after > PCNT_W'(0)) && lead_present_eff[0]) ?
                      lead_value_eff[0] : VALUE_W'(1);
   assign col_param = ((stored_after > PCNT_W'(1)) && lead_present_eff[1]) ?
                      lead_value_eff[1] : VALUE_W'(1);
   assign mode_param = ((stored_after > PCNT_W'(0)) && lead_present_eff[0]) ?
                       lead_value_eff[0] : '0;

   // Next state and command decode
   always_comb begin
      state_in     = state_ff;
      partial_in   = partial_ff;
      started_in   = started_ff;
      after_sep_in = after_sep_ff;
      stored_in    = stored_after;
      enq_valid    = 1'b0;
      enq_entry    = '0;
      if (do_push) begin
         partial_in = '0;
         started_in = 1'b0;
      end
      case (state_ff)
         ST_ESC: begin
            if (req_byte_in == CH_LBRACK) begin
               state_in     = ST_CSI;
               partial_in   = '0;
               started_in   = 1'b0;
               after_sep_in = 1'b0;
               stored_in    = '0;
            end else if (req_byte_in != CH_ESC) begin
               state_in     = ST_TEXT;
               partial_in   = '0;
               started_in   = 1'b0;
               after_sep_in = 1'b0;
               stored_in    = '0;
            end
         end
         ST_CSI: begin
            if (is_digit) begin
               partial_in   = (digit_acc > VALUE_MAX) ? {VALUE_W{1'b1}} : digit_acc[VALUE_W-1:0];
               started_in   = 1'b1;
               after_sep_in = 1'b0;
            end else if (is_semi) begin
               after_sep_in = 1'b1;
            end else if (is_letter) begin
               if ((req_byte_in == CH_H) || (req_byte_in == CH_F)) begin
                  enq_valid       = req_fire;
                  enq_entry.action = ACT_CURSOR;
                  enq_entry.arg_a  = row_param;
                  enq_entry.arg_b  = col_param;
               end else if (req_byte_in == CH_J) begin
                  enq_valid        = req_fire && (mode_param <= VALUE_W'(2));
                  enq_entry.action = ACT_CLEAR;
                  enq_entry.arg_a  = mode_param;
               end
               state_in     = ST_TEXT;
               partial_in   = '0;
               started_in   = 1'b0;
               after_sep_in = 1'b0;
               stored_in    = '0;
            end
         end
         default: begin
            // text state, and the unused code treated as text
            if (req_byte_in == CH_ESC) begin
               state_in = ST_ESC;
            end else begin
               state_in            = ST_TEXT;
               enq_valid           = req_fire;
               enq_entry.action    = ACT_PRINT;
               enq_entry.char_code = req_byte_in;
            end
         end
      endcase
   end

   // Parse state registers; advance on each accepted byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_TEXT;
         partial_ff   <= '0;
         started_ff   <= 1'b0;
         after_sep_ff <= 1'b0;
         stored_ff    <= '0;
      end else if (req_fire) begin
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         started_ff   <= started_in;
         after_sep_ff <= after_sep_in;
         stored_ff    <= stored_in;
      end
   end

   // Leading parameter slots
   always_ff @(posedge clock) begin
      for (int k = 0; k < LEAD_SLOTS; k++) begin
         if (lead_we[k]) begin
            lead_value_ff[k]   <= lead_value_eff[k];
            lead_present_ff[k] <= lead_present_eff[k];
         end
      end
   end

   // Sequence bookkeeping is idle outside CSI
   assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_CSI) |-> ((stored_ff == '0) && (partial_ff == '0) &&
                                !started_ff && !after_sep_ff))
      else $error("sequence state not cleared outside CSI");

   // Parameter count never passes its limit
   assert property (@(posedge clock) disable iff (reset)
      stored_ff <= PCNT_W'(MAX_PARAMS))
      else $error("parameter count overflow");

endmodule

[src/acep_queue.sv]
// Short command queue decoupling the parser from the executor.
module acep_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                enq_valid,
   input  acep_pkg::cmd_type   enq_entry,
   output logic                enq_full,
   output logic                deq_valid,
   output acep_pkg::cmd_type   deq_entry,
   input  logic                deq_stall
);
   import acep_pkg::*;

   cmd_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign enq_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign deq_valid = (count_ff != '0);
   assign deq_entry = entries_ff[rd_ptr_ff];
   assign push      = enq_valid && !enq_full;
   assign pop       = deq_valid && !deq_stall;

   // Advance pointers with wrap
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= enq_entry;
      end
   end

   // Occupancy never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("command queue overflow");

endmodule

[src/acep_back.sv]
// Command executor: screen size registers, cursor clamping and the result register.
module acep_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [acep_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [acep_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               deq_valid,
   input  acep_pkg::cmd_type                  deq_entry,
   output logic                               deq_stall,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [acep_pkg::ACTION_W-1:0]      rsp_action,
   output logic [acep_pkg::BYTE_W-1:0]        rsp_char_out,
   output logic [acep_pkg::VALUE_W-1:0]       rsp_cursor_row,
   output logic [acep_pkg::VALUE_W-1:0]       rsp_cursor_col,
   output logic [acep_pkg::MODE_W-1:0]        rsp_clear_mode
);
   import acep_pkg::*;

   logic [VALUE_W-1:0]  screen_rows_ff;
   logic [VALUE_W-1:0]  screen_cols_ff;
   logic                out_valid_ff, out_valid_in;
   logic [ACTION_W-1:0] action_ff;
   logic [BYTE_W-1:0]   char_ff;
   logic [VALUE_W-1:0]  row_ff, row_in;
   logic [VALUE_W-1:0]  col_ff, col_in;
   logic [MODE_W-1:0]   mode_ff;

   logic                pop;
   logic                drop;
   logic [VALUE_W-1:0]  row_raised, col_raised;
   logic [VALUE_W-1:0]  row_clamped, col_clamped;

   // Screen size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_rows_ff <= SCREEN_ROWS_RESET;
         screen_cols_ff <= SCREEN_COLS_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SCREEN_ROWS: screen_rows_ff <= csr_write_data;
            CSR_SCREEN_COLS: screen_cols_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Take a command whenever the result register is free or being drained
   assign deq_stall = out_valid_ff && rsp_stall;
   assign pop       = deq_valid && !deq_stall;
   assign drop      = (deq_entry.action == ACT_CURSOR) &&
                      ((screen_rows_ff == '0) || (screen_cols_ff == '0));

   // Raise zero to one, clamp to the screen, convert to zero-based
   assign row_raised  = (deq_entry.arg_a == '0) ? VALUE_W'(1) : deq_entry.arg_a;
   assign col_raised  = (deq_entry.arg_b == '0) ? VALUE_W'(1) : deq_entry.arg_b;
   assign row_clamped = (row_raised > screen_rows_ff) ? screen_rows_ff : row_raised;
   assign col_clamped = (col_raised > screen_cols_ff) ? screen_cols_ff : col_raised;
   assign row_in = (deq_entry.action == ACT_CURSOR) ? row_clamped - VALUE_W'(1) : '0;
   assign col_in = (deq_entry.action == ACT_CURSOR) ? col_clamped - VALUE_W'(1) : '0;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (pop) begin
         out_valid_in = !drop;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Load the result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         action_ff <= deq_entry.action;
         char_ff   <= (deq_entry.action == ACT_PRINT) ? deq_entry.char_code : '0;
         row_ff    <= row_in;
         col_ff    <= col_in;
         mode_ff   <= (deq_entry.action == ACT_CLEAR) ? deq_entry.arg_a[MODE_W-1:0] : '0;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_action     = action_ff;
   assign rsp_char_out   = char_ff;
   assign rsp_cursor_row = row_ff;
   assign rsp_cursor_col = col_ff;
   assign rsp_clear_mode = mode_ff;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_action == ACT_PRINT) || (rsp_action == ACT_CURSOR) ||
                     (rsp_action == ACT_CLEAR)))
      else $error("result with unknown action");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_PRINT)) |->
         ((rsp_cursor_row == '0) && (rsp_cursor_col == '0) && (rsp_clear_mode == '0)))
      else $error("print result carries stray fields");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_action == ACT_CLEAR)) |->
         ((rsp_clear_mode != 2'd3) && (rsp_char_out == '0) && (rsp_cursor_row == '0)))
      else $error("clear result malformed");

endmodule

[src/ansi_csi_escape_parser_core.sv]
// Top level of the ANSI CSI escape sequence parser.
// Takes one terminal output byte per cycle while req_stall is low and produces at
// most one transaction per byte: a printed character, a cursor move (ESC [ row ;
// col H or f, zero-based and clamped to the screen size) or a display clear (ESC [
// n J, n of 0..2). A byte's result passes through the command queue and the output
// register to the rsp_ side. The parser works at one byte per cycle while the queue
// has room; the two-entry command queue plus the output register absorb rsp_stall,
// so req_stall rises only once both queue entries wait behind a stalled result. The
// user must write the screen size registers through the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
module ansi_csi_escape_parser_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [acep_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [acep_pkg::CSR_DATA_W-1:0]    csr_write_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [acep_pkg::BYTE_W-1:0]        req_byte_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [acep_pkg::ACTION_W-1:0]      rsp_action,
   output logic [acep_pkg::BYTE_W-1:0]        rsp_char_out,
   output logic [acep_pkg::VALUE_W-1:0]       rsp_cursor_row,
   output logic [acep_pkg::VALUE_W-1:0]       rsp_cursor_col,
   output logic [acep_pkg::MODE_W-1:0]        rsp_clear_mode
);
   import acep_pkg::*;

   logic     enq_valid;
   cmd_type  enq_entry;
   logic     enq_full;
   logic     deq_valid;
   cmd_type  deq_entry;
   logic     deq_stall;

   acep_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_byte_in (req_byte_in),
      .enq_valid   (enq_valid),
      .enq_entry   (enq_entry),
      .enq_full    (enq_full)
   );

   acep_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_entry (enq_entry),
      .enq_full  (enq_full),
      .deq_valid (deq_valid),
      .deq_entry (deq_entry),
      .deq_stall (deq_stall)
   );

   acep_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .deq_valid        (deq_valid),
      .deq_entry        (deq_entry),
      .deq_stall        (deq_stall),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_action       (rsp_action),
      .rsp_char_out     (rsp_char_out),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_clear_mode   (rsp_clear_mode)
   );

endmodule
